[rtl/bia_pkg.sv]
// Shared constants and types for the bitmap ID allocator.
`timescale 1ns / 1ps

package bia_pkg;

    localparam int MAX_IDS     = 4096;
    localparam int GROUP_BITS  = 8;
    localparam int ID_W        = 13;
    localparam int WORD_W      = 64;
    localparam int WORD_AW     = 6;
    localparam int NUM_WORDS   = MAX_IDS / WORD_W;
    localparam logic [31:0] ALL_ONES_ID = 32'hffff_ffff;
    localparam logic [ID_W-1:0] ID_CAP  = ID_W'((MAX_IDS / GROUP_BITS) * GROUP_BITS);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_MARK  = 2'd1,
        OP_CHECK = 2'd2,
        OP_RAISE = 2'd3
    } op_t;

    // Result of the first-clear-bit search over one bitmap word.
    typedef struct packed {
        logic               found;
        logic [WORD_AW-1:0] idx;
    } find_t;

endpackage

[rtl/bia_find.sv]
// Priority finder: lowest set bit of a word of candidate free positions.
`timescale 1ns / 1ps

module bia_find (
    input  logic [bia_pkg::WORD_W-1:0] cand,
    output bia_pkg::find_t             res
);
    import bia_pkg::*;

    always_comb
    begin
        res.found = |cand;
        res.idx   = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                res.idx = WORD_AW'(j);
            end
        end
    end

endmodule

[rtl/bitmap_id_allocator.sv]
// Top level of the bitmap ID allocator: control sequencer and bitmap memory.
`timescale 1ns / 1ps

// The block keeps a 4096-bit ID bitmap in a synchronous memory of 64 words of
// 64 bits. Requests arrive on the input channel (in_valid / in_stall) as one
// beat of opcode, id_value and set_flag; each request yields exactly one
// result beat of status, is_set and new_id on the output channel
// (out_valid / out_stall). One request is worked on at a time, and in_stall
// is high while a request is in progress.
// Allocate from the counter and raise-counter go straight to the result
// stage; mark and check read one memory word, and mark writes it back when
// the bit changes. An allocate that searches the bitmap reads one 64-bit
// word per cycle through the single read port, over at most two passes.
// The user must write the max_id register through cfg_wr_en / cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
// The value is rounded up to a multiple of 8 and capped. At reset the
// counter and resume point clear, max_id returns to 4096 and the bitmap
// reads as all clear through a per-word valid bit, so no clearing pass is
// needed. If the receiver stalls, the result beat is held in the output
// register; the next request may be accepted meanwhile and its result
// waits inside the block until the output register frees up.

module bitmap_id_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [bia_pkg::ID_W-1:0]  cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                opcode,
    input  logic [31:0]               id_value,
    input  logic                      set_flag,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      status,
    output logic                      is_set,
    output logic [bia_pkg::ID_W-1:0]  new_id
);
    import bia_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MRD,
        S_MCHK,
        S_PASS,
        S_SCAN,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic                 setf_reg, setf_next;
    logic [11:0]          k_reg, k_next;
    logic [ID_W-1:0]      cnt_reg, cnt_next;
    logic [ID_W-1:0]      rp_reg, rp_next;
    logic [ID_W-1:0]      max_reg, max_next;
    logic                 pass_reg, pass_next;
    logic [ID_W-1:0]      s8_reg, s8_next;
    logic [ID_W-1:0]      lo_reg, lo_next;
    logic [ID_W-1:0]      hi_reg, hi_next;
    logic [WORD_AW-1:0]   whi_reg, whi_next;
    logic [WORD_AW-1:0]   rd_w_reg, rd_w_next;
    logic [WORD_AW-1:0]   chk_w_reg, chk_w_next;
    logic                 chkv_reg, chkv_next;
    logic                 r_status_reg, r_status_next;
    logic                 r_is_set_reg, r_is_set_next;
    logic [ID_W-1:0]      r_new_id_reg, r_new_id_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 status_reg, status_next;
    logic                 is_set_reg, is_set_next;
    logic [ID_W-1:0]      new_id_reg, new_id_next;
    logic [NUM_WORDS-1:0] vld_reg, vld_next;

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [WORD_W-1:0]    mem_q;
    logic                 mem_we;
    logic [WORD_AW-1:0]   mem_wa;
    logic [WORD_AW-1:0]   mem_ra;
    logic [WORD_W-1:0]    mem_wd;

    logic [WORD_W-1:0]    scan_word;
    logic [WORD_W-1:0]    scan_mask;
    find_t                find_res;

    logic                 in_fire;
    logic                 id_gt_max;
    logic [ID_W-1:0]      rp_eff;
    logic [13:0]          cfg_sum;
    logic [13:0]          cfg_rnd;
    logic [ID_W-1:0]      pass_lo;
    logic [ID_W-1:0]      pass_hi;
    logic [ID_W-1:0]      hi_m1;
    logic [WORD_W-1:0]    chk_word;
    logic                 chk_bit;
    logic [11:0]          found_pos;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign is_set    = is_set_reg;
    assign new_id    = new_id_reg;

    assign id_gt_max = ({19'd0, max_reg} < id_value);

    // Words never written since reset read as all clear.
    assign chk_word  = vld_reg[k_reg[11:6]] ? mem_q : '0;
    assign chk_bit   = chk_word[k_reg[5:0]];
    assign scan_word = vld_reg[chk_w_reg] ? mem_q : '0;

    // Candidate positions in the word under check lie in [lo, hi).
    always_comb
    begin
        logic [ID_W-1:0] p;
        for (int j = 0; j < WORD_W; j++)
        begin
            p = {1'b0, chk_w_reg, WORD_AW'(j)};
            scan_mask[j] = (p >= lo_reg) && (p < hi_reg);
        end
    end

    bia_find u_find (
        .cand (~scan_word & scan_mask),
        .res  (find_res)
    );

    assign found_pos = {chk_w_reg, find_res.idx};
    assign mem_ra    = (state_reg == S_SCAN) ? rd_w_reg : k_reg[11:6];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        setf_next      = setf_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        rp_next        = rp_reg;
        max_next       = max_reg;
        pass_next      = pass_reg;
        s8_next        = s8_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        whi_next       = whi_reg;
        rd_w_next      = rd_w_reg;
        chk_w_next     = chk_w_reg;
        chkv_next      = chkv_reg;
        r_status_next  = r_status_reg;
        r_is_set_next  = r_is_set_reg;
        r_new_id_next  = r_new_id_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        is_set_next    = is_set_reg;
        new_id_next    = new_id_reg;
        vld_next       = vld_reg;
        mem_we         = 1'b0;
        mem_wa         = k_reg[11:6];
        mem_wd         = chk_word;
        rp_eff         = (rp_reg == max_reg) ? '0 : rp_reg;
        pass_lo        = pass_reg ? '0 : s8_reg;
        pass_hi        = (pass_reg && (s8_reg < max_reg)) ? s8_reg : max_reg;
        hi_m1          = pass_hi - ID_W'(1);

        // Configuration: round up to a group boundary and cap.
        cfg_sum = {1'b0, cfg_wr_data} + 14'd7;
        cfg_rnd = {cfg_sum[13:3], 3'b000};
        if (cfg_wr_en)
        begin
            max_next = (cfg_rnd > {1'b0, ID_CAP}) ? ID_CAP : cfg_rnd[ID_W-1:0];
        end

        // The output register drains when the receiver takes the beat.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next       = op_t'(opcode);
                    setf_next     = set_flag;
                    k_next        = (id_value[ID_W-1:0] == max_reg) ? '0 : id_value[11:0];
                    r_status_next = 1'b0;
                    r_is_set_next = 1'b0;
                    r_new_id_next = '0;
                    state_next    = S_OUT;
                    case (op_t'(opcode))
                        OP_ALLOC:
                        begin
                            if (cnt_reg < max_reg)
                            begin
                                cnt_next      = cnt_reg + ID_W'(1);
                                r_new_id_next = cnt_reg + ID_W'(1);
                            end
                            else
                            begin
                                rp_next    = rp_eff;
                                s8_next    = {rp_eff[ID_W-1:3], 3'b000};
                                pass_next  = 1'b0;
                                state_next = S_PASS;
                            end
                        end
                        OP_MARK:
                        begin
                            if (id_gt_max)
                            begin
                                r_status_next = (id_value == ALL_ONES_ID);
                            end
                            else
                            begin
                                state_next = S_MRD;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (id_gt_max)
                            begin
                                r_status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MRD;
                            end
                        end
                        OP_RAISE:
                        begin
                            if ((id_value != 32'd0) && !id_gt_max &&
                                (cnt_reg < id_value[ID_W-1:0]))
                            begin
                                cnt_next = id_value[ID_W-1:0];
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_MRD:
            begin
                state_next = S_MCHK;
            end
            S_MCHK:
            begin
                if (op_reg == OP_CHECK)
                begin
                    r_is_set_next = chk_bit;
                end
                else if (chk_bit == setf_reg)
                begin
                    r_status_next = 1'b1;
                end
                else
                begin
                    mem_we                 = 1'b1;
                    mem_wd[k_reg[5:0]]     = setf_reg;
                    vld_next[k_reg[11:6]]  = 1'b1;
                end
                state_next = S_OUT;
            end
            S_PASS:
            begin
                if (pass_lo < pass_hi)
                begin
                    lo_next    = pass_lo;
                    hi_next    = pass_hi;
                    whi_next   = hi_m1[11:6];
                    rd_w_next  = pass_lo[11:6];
                    chkv_next  = 1'b0;
                    state_next = S_SCAN;
                end
                else if (!pass_reg && (s8_reg != '0))
                begin
                    pass_next = 1'b1;
                end
                else
                begin
                    r_status_next = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_SCAN:
            begin
                // A read is issued every cycle; the word read in the previous
                // cycle is checked while the next one is fetched.
                chk_w_next = rd_w_reg;
                chkv_next  = 1'b1;
                if (rd_w_reg < whi_reg)
                begin
                    rd_w_next = rd_w_reg + WORD_AW'(1);
                end
                if (chkv_reg)
                begin
                    if (find_res.found)
                    begin
                        rp_next       = (found_pos == '0) ? max_reg : {1'b0, found_pos};
                        r_new_id_next = (found_pos == '0) ? max_reg : {1'b0, found_pos};
                        state_next    = S_OUT;
                    end
                    else if (chk_w_reg == whi_reg)
                    begin
                        if (!pass_reg && (s8_reg != '0))
                        begin
                            pass_next  = 1'b1;
                            state_next = S_PASS;
                        end
                        else
                        begin
                            r_status_next = 1'b1;
                            state_next    = S_OUT;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = r_status_reg;
                    is_set_next    = r_is_set_reg;
                    new_id_next    = r_new_id_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Bitmap store: one write and one registered read per cycle. Only one
    // request is in flight, so a write always lands before the next read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rp_reg        <= '0;
            max_reg       <= ID_CAP;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            chkv_reg      <= 1'b0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rp_reg        <= rp_next;
            max_reg       <= max_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
            chkv_reg      <= chkv_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        setf_reg     <= setf_next;
        k_reg        <= k_next;
        s8_reg       <= s8_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        whi_reg      <= whi_next;
        rd_w_reg     <= rd_w_next;
        chk_w_reg    <= chk_w_next;
        r_status_reg <= r_status_next;
        r_is_set_reg <= r_is_set_next;
        r_new_id_reg <= r_new_id_next;
        status_reg   <= status_next;
        is_set_reg   <= is_set_next;
        new_id_reg   <= new_id_next;
    end

    // The bitmap is only written while a mark is being resolved.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_MCHK) && (op_reg == OP_MARK))
        else $error("bitmap written outside a mark");

    // The fetch pointer never runs past the last word of the current pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rd_w_reg <= whi_reg))
        else $error("search pointer beyond pass end");

    // A beat handed out with an ID never reports failure.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (new_id != '0)) |-> !status)
        else $error("ID returned with failure status");

    // A result moves to the output only when the register is free or drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_valid_reg && out_stall) |=> (state_reg == S_OUT))
        else $error("result left the pending stage while output was stalled");

endmodule
